// ===== hdl/sdfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfp_pkg
// Types and constants shared by the sync/destination frame parser.
// ----------------------------------------------------------------------------
package sdfp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned WCMD_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Fixed payload length of a UTC time frame
    localparam logic [LEN_W-1:0] UTC_LEN = 16'd6;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_DEST  = 3'd1,
        PH_CMD   = 3'd2,
        PH_LENH  = 3'd3,
        PH_LENL  = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHECK = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        K_RESTRUCT = 2'd0,
        K_INTO     = 2'd1,
        K_UTC      = 2'd2,
        K_NONE     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_CHECK  = 3'd1,
        ST_LONG   = 3'd2,
        ST_DEST   = 3'd3,
        ST_CMD    = 3'd4,
        ST_UTCLEN = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OK_PAYLOAD = 2'd0,
        OK_DONE    = 2'd1,
        OK_DROP    = 2'd2
    } t_out_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_BYTE    = 3'd0,
        CFG_BOUND_DEST   = 3'd1,
        CFG_ACCEPT_ANY   = 3'd2,
        CFG_CODE_RESTR   = 3'd3,
        CFG_CODE_INTO    = 3'd4,
        CFG_CODE_UTC     = 3'd5,
        CFG_MAX_RESTR    = 3'd6,
        CFG_MAX_INTO     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_out_kind         out_kind;
        logic [BYTE_W-1:0] payload_byte;
        t_kind             frame_kind;
        t_status           frame_status;
        logic [CNT_W-1:0]  discard_total;
        logic [CNT_W-1:0]  into_error_total;
        logic [WCMD_W-1:0] wrong_cmd_count;
    } t_result;

endpackage

// ===== hdl/sdfp_in_if.sv =====
// ----------------------------------------------------------------------------
// sdfp_in_if
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface sdfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/sdfp_out_if.sv =====
// ----------------------------------------------------------------------------
// sdfp_out_if
// Valid/ready channel carrying one parser result per transaction.
// ----------------------------------------------------------------------------
interface sdfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_kind;
    logic [2:0]  frame_status;
    logic [15:0] discard_total;
    logic [15:0] into_error_total;
    logic [2:0]  wrong_cmd_count;

    modport source (
        output valid, output out_kind, output payload_byte, output frame_kind,
        output frame_status, output discard_total, output into_error_total,
        output wrong_cmd_count, input ready
    );
    modport sink (
        input valid, input out_kind, input payload_byte, input frame_kind,
        input frame_status, input discard_total, input into_error_total,
        input wrong_cmd_count, output ready
    );
endinterface

// ===== hdl/sync_dest_frame_parser_xor_check.sv =====
// ----------------------------------------------------------------------------
// sync_dest_frame_parser_xor_check
// Byte-stream frame parser: sync, destination, command, length, payload,
// XOR check byte, with discard and error counters.
//
// One received byte is taken per transaction on i_in, one byte per clock
// when the result side keeps up. Each byte is handled in the cycle it is
// accepted: the parser state, counters and result are computed by a single
// layer of logic and stored, so a new byte can follow every cycle. Payload
// bytes come out one per transaction on o_out (out_kind 0), the check byte
// closes the frame with a status (out_kind 1), and a frame rejected for a
// wrong destination, unknown command or excess length is reported once as
// dropped (out_kind 2). Sync, destination, command and length bytes give
// no other result. Results pass through a two-entry output register, so
// i_in stays ready while one result waits. Configuration must be written
// through i_cfg_we / i_cfg_idx / i_cfg_data only while the parser is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sync_dest_frame_parser_xor_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdfp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sdfp_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    sdfp_in_if.sink                           i_in,
    sdfp_out_if.source                        o_out
);
    import sdfp_pkg::*;

    // ---------------- configuration registers ----------------
    logic [BYTE_W-1:0] r_sync_byte;
    logic [BYTE_W-1:0] r_bound_dest;
    logic              r_accept_any;
    logic [BYTE_W-1:0] r_code_restr;
    logic [BYTE_W-1:0] r_code_into;
    logic [BYTE_W-1:0] r_code_utc;
    logic [LEN_W-1:0]  r_max_restr;
    logic [LEN_W-1:0]  r_max_into;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte  <= '0;
            r_bound_dest <= '0;
            r_accept_any <= 1'b1;
            r_code_restr <= '0;
            r_code_into  <= '0;
            r_code_utc   <= '0;
            r_max_restr  <= '0;
            r_max_into   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SYNC_BYTE:  r_sync_byte  <= i_cfg_data[BYTE_W-1:0];
                CFG_BOUND_DEST: r_bound_dest <= i_cfg_data[BYTE_W-1:0];
                CFG_ACCEPT_ANY: r_accept_any <= i_cfg_data[0];
                CFG_CODE_RESTR: r_code_restr <= i_cfg_data[BYTE_W-1:0];
                CFG_CODE_INTO:  r_code_into  <= i_cfg_data[BYTE_W-1:0];
                CFG_CODE_UTC:   r_code_utc   <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_RESTR:  r_max_restr  <= i_cfg_data[LEN_W-1:0];
                CFG_MAX_INTO:   r_max_into   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- parser state ----------------
    t_phase            r_phase,  n_phase;
    t_kind             r_kind,   n_kind;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [LEN_W-1:0]  r_left,   n_left;
    logic [LEN_W-1:0]  r_flen,   n_flen;
    logic [BYTE_W-1:0] r_xor,    n_xor;
    logic [CNT_W-1:0]  r_disc,   n_disc;
    logic [CNT_W-1:0]  r_ierr,   n_ierr;
    logic [WCMD_W-1:0] r_wcmd,   n_wcmd;

    logic              in_rdy;
    logic              in_acc;
    logic [BYTE_W-1:0] rx;
    logic [LEN_W-1:0]  len_now;
    logic [LEN_W-1:0]  max_len;

    logic              res_vld;
    t_out_kind         res_okind;
    logic [BYTE_W-1:0] res_byte;
    t_kind             res_fkind;
    t_status           res_st;
    t_result           res;
    t_result           out_data;

    assign i_in.ready = in_rdy;
    assign in_acc     = i_in.valid && in_rdy;
    assign rx         = i_in.rx_byte;
    assign len_now    = {r_len_hi, rx};

    // Length limit for the kind latched from the command byte
    always_comb begin
        case (r_kind)
            K_RESTRUCT: max_len = r_max_restr;
            K_INTO:     max_len = r_max_into;
            default:    max_len = UTC_LEN;
        endcase
    end

    // Next state and result for the byte accepted this cycle
    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_len_hi  = r_len_hi;
        n_left    = r_left;
        n_flen    = r_flen;
        n_xor     = r_xor;
        n_disc    = r_disc;
        n_ierr    = r_ierr;
        n_wcmd    = r_wcmd;
        res_vld   = 1'b0;
        res_okind = OK_PAYLOAD;
        res_byte  = '0;
        res_fkind = r_kind;
        res_st    = ST_OK;
        if (in_acc) begin
            case (r_phase)
                PH_HUNT: begin
                    if (rx == r_sync_byte) begin
                        n_phase = PH_DEST;
                    end
                end
                PH_DEST: begin
                    if (r_accept_any || rx == r_bound_dest) begin
                        n_phase = PH_CMD;
                    end else begin
                        // destination byte is not re-examined as sync
                        n_phase   = PH_HUNT;
                        n_disc    = r_disc + 1'b1;
                        res_vld   = 1'b1;
                        res_okind = OK_DROP;
                        res_fkind = K_NONE;
                        res_st    = ST_DEST;
                    end
                end
                PH_CMD: begin
                    // priority on equal codes: restructure, into-data, UTC
                    n_xor   = r_sync_byte ^ r_bound_dest ^ rx;
                    n_phase = PH_LENH;
                    if (rx == r_code_restr) begin
                        n_kind = K_RESTRUCT;
                    end else if (rx == r_code_into) begin
                        n_kind = K_INTO;
                    end else if (rx == r_code_utc) begin
                        n_kind = K_UTC;
                    end else begin
                        n_xor     = r_xor;
                        n_phase   = PH_HUNT;
                        n_disc    = r_disc + 1'b1;
                        res_vld   = 1'b1;
                        res_okind = OK_DROP;
                        res_fkind = K_NONE;
                        res_st    = ST_CMD;
                    end
                end
                PH_LENH: begin
                    n_len_hi = rx;
                    n_xor    = r_xor ^ rx;
                    n_phase  = PH_LENL;
                end
                PH_LENL: begin
                    n_xor  = r_xor ^ rx;
                    n_flen = len_now;
                    if (len_now > max_len) begin
                        n_phase   = PH_HUNT;
                        n_disc    = r_disc + 1'b1;
                        res_vld   = 1'b1;
                        res_okind = OK_DROP;
                        res_st    = ST_LONG;
                    end else begin
                        n_left  = len_now;
                        n_phase = (len_now == '0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_xor    = r_xor ^ rx;
                    n_left   = r_left - 1'b1;
                    if (r_left == LEN_W'(1)) begin
                        n_phase = PH_CHECK;
                    end
                    res_vld  = 1'b1;
                    res_byte = rx;
                end
                PH_CHECK: begin
                    n_phase   = PH_HUNT;
                    res_vld   = 1'b1;
                    res_okind = OK_DONE;
                    // restructure frames carry no checked status
                    if (r_kind != K_RESTRUCT) begin
                        if (rx != r_xor) begin
                            res_st = ST_CHECK;
                            if (r_kind == K_INTO) begin
                                n_ierr = r_ierr + 1'b1;
                                n_wcmd = r_wcmd + 1'b1;
                            end else begin
                                n_disc = r_disc + 1'b1;
                            end
                        end else if (r_kind == K_UTC && r_flen != UTC_LEN) begin
                            res_st = ST_UTCLEN;
                            n_disc = r_disc + 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_kind   <= K_RESTRUCT;
            r_len_hi <= '0;
            r_left   <= '0;
            r_flen   <= '0;
            r_xor    <= '0;
            r_disc   <= '0;
            r_ierr   <= '0;
            r_wcmd   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_len_hi <= n_len_hi;
            r_left   <= n_left;
            r_flen   <= n_flen;
            r_xor    <= n_xor;
            r_disc   <= n_disc;
            r_ierr   <= n_ierr;
            r_wcmd   <= n_wcmd;
        end
    end

    // Result carries the counters as they stand after this byte
    always_comb begin
        res.out_kind         = res_okind;
        res.payload_byte     = res_byte;
        res.frame_kind       = res_fkind;
        res.frame_status     = res_st;
        res.discard_total    = n_disc;
        res.into_error_total = n_ierr;
        res.wrong_cmd_count  = n_wcmd;
    end

    // ---------------- output register with skid stage ----------------
    sdfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (res_vld),
        .i_data  (res),
        .o_rdy   (in_rdy),
        .o_vld   (o_out.valid),
        .o_data  (out_data),
        .i_rdy   (o_out.ready)
    );

    assign o_out.out_kind         = out_data.out_kind;
    assign o_out.payload_byte     = out_data.payload_byte;
    assign o_out.frame_kind       = out_data.frame_kind;
    assign o_out.frame_status     = out_data.frame_status;
    assign o_out.discard_total    = out_data.discard_total;
    assign o_out.into_error_total = out_data.into_error_total;
    assign o_out.wrong_cmd_count  = out_data.wrong_cmd_count;

endmodule

// ===== hdl/sdfp_out_buf.sv =====
// ----------------------------------------------------------------------------
// sdfp_out_buf
// Two-entry output register with skid stage; full throughput, registered out.
// ----------------------------------------------------------------------------
module sdfp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  sdfp_pkg::t_result i_data,
    output logic              o_rdy,
    output logic              o_vld,
    output sdfp_pkg::t_result o_data,
    input  logic              i_rdy
);
    import sdfp_pkg::*;

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_vld || i_rdy;
    assign o_rdy    = !r_skid_vld;
    assign o_vld    = r_out_vld;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (i_vld) begin
            if (out_free) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_rdy) begin
            r_out_vld <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (i_vld) begin
            if (out_free) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

// ===== tb/sync_dest_frame_parser_xor_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_dest_frame_parser_xor_check_tb
// Drives byte streams into the frame parser and checks every result against
// a cycle-free model of the parser. The stimulus is a short directed run of
// frames, then phases of random frames under several register settings. The
// phases vary the idle pattern on both channels. One phase holds the result
// channel off for a long stretch, and one pauses the byte stream until all
// pending results have drained.
// ----------------------------------------------------------------------------
module sync_dest_frame_parser_xor_check_tb;
    import sdfp_pkg::*;

    // Register set as the parser sees it, one field per register
    typedef struct {
        logic [7:0]  sync_val;
        logic [7:0]  bound_id;
        logic        any_dest;
        logic [7:0]  cmd_restr;
        logic [7:0]  cmd_into;
        logic [7:0]  cmd_utc;
        logic [15:0] max_restr;
        logic [15:0] max_into;
    } t_parser_cfg;

    // ------------------------------------------------------------------------
    // Frame tracker: mirrors the parser state and counters, queues the
    // results each accepted byte should produce and checks them in order.
    // ------------------------------------------------------------------------
    class t_frame_tracker;
        logic [7:0]  sync_val, bound_id, cmd_restr, cmd_into, cmd_utc;
        logic        any_dest;
        logic [15:0] max_restr, max_into;

        t_phase      phase;
        t_kind       kind_q;
        logic [7:0]  len_hi;
        logic [7:0]  xor_acc;
        logic [15:0] left;
        logic [15:0] flen;
        logic [15:0] n_discard;
        logic [15:0] n_into_err;
        logic [2:0]  n_wrong_cmd;

        t_result     due_results[$];
        int          mismatches;

        function new();
            sync_val    = 8'h00;
            bound_id    = 8'h00;
            any_dest    = 1'b1;
            cmd_restr   = 8'h00;
            cmd_into    = 8'h00;
            cmd_utc     = 8'h00;
            max_restr   = 16'h0000;
            max_into    = 16'h0000;
            phase       = PH_HUNT;
            kind_q      = K_RESTRUCT;
            len_hi      = 8'h00;
            xor_acc     = 8'h00;
            left        = 16'h0000;
            flen        = 16'h0000;
            n_discard   = 16'h0000;
            n_into_err  = 16'h0000;
            n_wrong_cmd = 3'd0;
            mismatches  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_SYNC_BYTE:  sync_val  = data[7:0];
                CFG_BOUND_DEST: bound_id  = data[7:0];
                CFG_ACCEPT_ANY: any_dest  = data[0];
                CFG_CODE_RESTR: cmd_restr = data[7:0];
                CFG_CODE_INTO:  cmd_into  = data[7:0];
                CFG_CODE_UTC:   cmd_utc   = data[7:0];
                CFG_MAX_RESTR:  max_restr = data;
                CFG_MAX_INTO:   max_into  = data;
                default: ;
            endcase
        endfunction

        // Counters are sampled after the byte's own update
        function void post(t_out_kind ok, logic [7:0] b, t_kind fk, t_status st);
            t_result r;
            r.out_kind         = ok;
            r.payload_byte     = b;
            r.frame_kind       = fk;
            r.frame_status     = st;
            r.discard_total    = n_discard;
            r.into_error_total = n_into_err;
            r.wrong_cmd_count  = n_wrong_cmd;
            due_results.push_back(r);
        endfunction

        // Note one accepted byte transaction
        function void take_byte(logic [7:0] b);
            logic [15:0] limit;
            t_status     st;
            case (phase)
                PH_HUNT: begin
                    if (b == sync_val) phase = PH_DEST;
                end
                PH_DEST: begin
                    if (any_dest || b == bound_id) begin
                        phase = PH_CMD;
                    end else begin
                        // wrong destination byte is not re-examined as sync
                        phase     = PH_HUNT;
                        n_discard = n_discard + 16'd1;
                        post(OK_DROP, 8'h00, K_NONE, ST_DEST);
                    end
                end
                PH_CMD: begin
                    // on coinciding codes restructure wins, then into-data
                    if (b == cmd_restr || b == cmd_into || b == cmd_utc) begin
                        if (b == cmd_restr) begin
                            kind_q = K_RESTRUCT;
                        end else if (b == cmd_into) begin
                            kind_q = K_INTO;
                        end else begin
                            kind_q = K_UTC;
                        end
                        xor_acc = sync_val ^ bound_id ^ b;
                        phase   = PH_LENH;
                    end else begin
                        phase     = PH_HUNT;
                        n_discard = n_discard + 16'd1;
                        post(OK_DROP, 8'h00, K_NONE, ST_CMD);
                    end
                end
                PH_LENH: begin
                    len_hi  = b;
                    xor_acc = xor_acc ^ b;
                    phase   = PH_LENL;
                end
                PH_LENL: begin
                    xor_acc = xor_acc ^ b;
                    flen    = {len_hi, b};
                    if (kind_q == K_RESTRUCT) begin
                        limit = max_restr;
                    end else if (kind_q == K_INTO) begin
                        limit = max_into;
                    end else begin
                        limit = UTC_LEN;
                    end
                    if (flen > limit) begin
                        phase     = PH_HUNT;
                        n_discard = n_discard + 16'd1;
                        post(OK_DROP, 8'h00, kind_q, ST_LONG);
                    end else begin
                        left = flen;
                        // zero length: next byte is the check byte
                        if (flen == 16'd0) begin
                            phase = PH_CHECK;
                        end else begin
                            phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    xor_acc = xor_acc ^ b;
                    left    = left - 16'd1;
                    if (left == 16'd0) phase = PH_CHECK;
                    post(OK_PAYLOAD, b, kind_q, ST_OK);
                end
                PH_CHECK: begin
                    phase = PH_HUNT;
                    st    = ST_OK;
                    // restructure frames skip the check entirely
                    if (kind_q != K_RESTRUCT) begin
                        if (b != xor_acc) begin
                            st = ST_CHECK;
                            if (kind_q == K_INTO) begin
                                n_into_err  = n_into_err + 16'd1;
                                n_wrong_cmd = n_wrong_cmd + 3'd1;
                            end else begin
                                n_discard = n_discard + 16'd1;
                            end
                        end else if (kind_q == K_UTC && flen != UTC_LEN) begin
                            st        = ST_UTCLEN;
                            n_discard = n_discard + 16'd1;
                        end
                    end
                    post(OK_DONE, 8'h00, kind_q, st);
                end
                default: begin
                    phase = PH_HUNT;
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        // Check one accepted result transaction against the oldest expectation
        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result with nothing pending: out_kind %0d, frame_status %0d",
                       got.out_kind, got.frame_status);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("out_kind", want.out_kind, got.out_kind);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("frame_kind", want.frame_kind, got.frame_kind);
                check_field("frame_status", want.frame_status, got.frame_status);
                check_field("discard_total", want.discard_total, got.discard_total);
                check_field("into_error_total", want.into_error_total,
                            got.into_error_total);
                check_field("wrong_cmd_count", want.wrong_cmd_count, got.wrong_cmd_count);
            end
        endfunction
    endclass

    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 260;
    localparam int END_WAIT_MAX  = 10000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    sdfp_in_if  in_if ();
    sdfp_out_if out_if ();

    t_frame_tracker tracker;

    int send_idle_pct = 0;   // chance in percent of an idle cycle before a byte
    int recv_idle_pct = 0;   // chance in percent of ready low on a cycle
    int bytes_sent    = 0;
    int hold_req      = 0;   // bumped by the stimulus to request a long hold-off
    int hold_seen     = 0;
    int hold_left     = 0;

    // Directed frames, with sync A5, destination 3C, codes 10/20/30,
    // max lengths 4 (restructure) and 3 (into-data):
    //   wrong destination; unknown command FF; zero-length into-data with a
    //   bad check; UTC longer than its fixed length; restructure with one
    //   FF payload byte and an arbitrary check byte.
    logic [7:0] directed_frames[$] = '{
        8'hA5, 8'h00,
        8'hA5, 8'h3C, 8'hFF,
        8'hA5, 8'h3C, 8'h20, 8'h00, 8'h00, 8'h00,
        8'hA5, 8'h3C, 8'h30, 8'h00, 8'h07,
        8'hA5, 8'h3C, 8'h10, 8'h00, 8'h01, 8'hFF, 8'h00
    };

    sync_dest_frame_parser_xor_check u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout: run did not complete");
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random ready, plus a long counted hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every result transaction is checked as it is accepted
    always @(posedge i_clk) begin : result_monitor
        t_result seen;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen.out_kind         = t_out_kind'(out_if.out_kind);
            seen.payload_byte     = out_if.payload_byte;
            seen.frame_kind       = t_kind'(out_if.frame_kind);
            seen.frame_status     = t_status'(out_if.frame_status);
            seen.discard_total    = out_if.discard_total;
            seen.into_error_total = out_if.into_error_total;
            seen.wrong_cmd_count  = out_if.wrong_cmd_count;
            tracker.match_result(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // Offer one byte, with random idle cycles first; returns in the time step
    // of the edge that accepted the transaction. valid stays high so the next
    // byte can follow back to back.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    // Finish any partial frame, stop offering, and wait until every pending
    // result is out.
    task automatic drain_parser();
        while (tracker.phase != PH_HUNT) send_byte(8'($urandom_range(255)));
        in_if.valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    // All registers, back to back; only called with the parser idle
    task automatic program_parser(t_parser_cfg c);
        write_reg(CFG_SYNC_BYTE,  {8'h00, c.sync_val});
        write_reg(CFG_BOUND_DEST, {8'h00, c.bound_id});
        write_reg(CFG_ACCEPT_ANY, {15'h0000, c.any_dest});
        write_reg(CFG_CODE_RESTR, {8'h00, c.cmd_restr});
        write_reg(CFG_CODE_INTO,  {8'h00, c.cmd_into});
        write_reg(CFG_CODE_UTC,   {8'h00, c.cmd_utc});
        write_reg(CFG_MAX_RESTR,  c.max_restr);
        write_reg(CFG_MAX_INTO,   c.max_into);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_parser_cfg random_cfg(bit distinct);
        t_parser_cfg c;
        c.sync_val  = 8'($urandom_range(255));
        c.bound_id  = 8'($urandom_range(255));
        c.any_dest  = distinct ? 1'b0 : 1'($urandom_range(1));
        c.cmd_restr = 8'($urandom_range(255));
        c.cmd_into  = 8'($urandom_range(255));
        c.cmd_utc   = 8'($urandom_range(255));
        if (distinct) begin
            while (c.cmd_into == c.cmd_restr) c.cmd_into = 8'($urandom_range(255));
            while (c.cmd_utc == c.cmd_restr || c.cmd_utc == c.cmd_into)
                c.cmd_utc = 8'($urandom_range(255));
        end else begin
            // sometimes let codes collide to exercise the priority order
            if ($urandom_range(2) == 0) c.cmd_into = c.cmd_restr;
            if ($urandom_range(2) == 0) c.cmd_utc = c.cmd_into;
        end
        c.max_restr = 16'($urandom_range(24));
        c.max_into  = 16'($urandom_range(24));
        return c;
    endfunction

    // One frame built from the current register set: mostly well formed,
    // with some wrong destinations, unknown commands, oversize lengths,
    // off-size UTC frames and corrupted check bytes.
    task automatic send_frame();
        logic [7:0]  cmd, dst, chk, pay;
        logic [15:0] flen, cap;
        bit          known, is_utc;
        int          roll;
        roll  = $urandom_range(99);
        known = 1'b1;
        if (roll < 28) begin
            cmd = tracker.cmd_restr;
        end else if (roll < 56) begin
            cmd = tracker.cmd_into;
        end else if (roll < 88) begin
            cmd = tracker.cmd_utc;
        end else begin
            known = 1'b0;
            cmd   = 8'($urandom_range(255));
            while (cmd == tracker.cmd_restr || cmd == tracker.cmd_into ||
                   cmd == tracker.cmd_utc)
                cmd = 8'($urandom_range(255));
        end
        is_utc = (cmd != tracker.cmd_restr && cmd != tracker.cmd_into);
        if (cmd == tracker.cmd_restr) begin
            cap = tracker.max_restr;
        end else if (cmd == tracker.cmd_into) begin
            cap = tracker.max_into;
        end else begin
            cap = UTC_LEN;
        end

        dst = tracker.bound_id;
        if (tracker.any_dest ? ($urandom_range(1) == 1) : ($urandom_range(99) < 10)) begin
            while (dst == tracker.bound_id) dst = 8'($urandom_range(255));
        end

        send_byte(tracker.sync_val);
        send_byte(dst);
        if (!tracker.any_dest && dst != tracker.bound_id) return;
        send_byte(cmd);
        if (!known) return;

        roll = $urandom_range(99);
        if (roll < 12 && cap < 16'hFF00) begin
            if ($urandom_range(1) == 1) begin
                flen = cap + 16'($urandom_range(3, 1));
            end else begin
                flen = 16'($urandom_range(65535, int'(cap) + 1));
            end
        end else if (is_utc) begin
            flen = (roll < 75) ? UTC_LEN : 16'($urandom_range(UTC_LEN));
        end else begin
            flen = 16'($urandom_range((cap < 16'd16) ? cap : 16'd16));
        end

        chk = tracker.sync_val ^ tracker.bound_id ^ cmd ^ flen[15:8] ^ flen[7:0];
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
        if (flen > cap) return;
        for (int i = 0; i < flen; i++) begin
            pay = 8'($urandom_range(255));
            chk = chk ^ pay;
            send_byte(pay);
        end
        if ($urandom_range(99) < 22) chk = chk ^ 8'($urandom_range(255, 1));
        send_byte(chk);
    endtask

    // One phase: program the registers with the parser idle, then stream random
    // frames and, if with_noise, bursts of noise (which break frames apart).
    task automatic run_phase(t_parser_cfg c, int snd_pct, int rcv_pct, bit with_noise,
                             bit hold, bit pause_midway);
        int start_cnt;
        bit paused;
        drain_parser();
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        program_parser(c);
        // long receiver hold-off while bytes keep coming: fills the output
        // register and backs up the byte channel
        if (hold) hold_req <= hold_req + 1;
        start_cnt = bytes_sent;
        paused    = 1'b0;
        while (bytes_sent - start_cnt < PHASE_BYTES) begin
            if (with_noise && $urandom_range(99) < 15) begin
                repeat ($urandom_range(4, 1))
                    send_byte(($urandom_range(3) == 0) ? tracker.sync_val
                                                        : 8'($urandom_range(255)));
            end else begin
                send_frame();
            end
            // byte stream pauses until every pending result has come out
            if (pause_midway && !paused && bytes_sent - start_cnt >= PHASE_BYTES / 2) begin
                drain_parser();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int wait_cycles;
        tracker       = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.rx_byte = 8'h00;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames: sender idles 15%, receiver 48%
        send_idle_pct = 15;
        recv_idle_pct = 48;
        program_parser('{sync_val: 8'hA5, bound_id: 8'h3C, any_dest: 1'b0,
                         cmd_restr: 8'h10, cmd_into: 8'h20, cmd_utc: 8'h30,
                         max_restr: 16'd4, max_into: 16'd3});
        foreach (directed_frames[i]) send_byte(directed_frames[i]);

        // Low extremes: all codes equal (restructure always wins), lengths 0
        run_phase('{sync_val: 8'h00, bound_id: 8'h00, any_dest: 1'b1,
                    cmd_restr: 8'h00, cmd_into: 8'h00, cmd_utc: 8'h00,
                    max_restr: 16'd0, max_into: 16'd0}, 15, 48, 1'b1, 1'b0, 1'b0);

        // High extremes, strict destination, restructure shadows into-data;
        // long receiver hold-off in this phase
        run_phase('{sync_val: 8'hFF, bound_id: 8'hFF, any_dest: 1'b0,
                    cmd_restr: 8'h55, cmd_into: 8'h55, cmd_utc: 8'hAA,
                    max_restr: 16'd40, max_into: 16'd12}, 15, 48, 1'b1, 1'b1, 1'b0);

        // Now the sender idles more than the receiver; distinct codes,
        // with a full drain in the middle
        run_phase(random_cfg(1'b1), 48, 15, 1'b1, 1'b0, 1'b1);

        // into-data shadows UTC, largest into-data limit; whole frames
        // only, no noise bursts, so no broken frame can pick up a huge length
        run_phase('{sync_val: 8'h7E, bound_id: 8'h01, any_dest: 1'b1,
                    cmd_restr: 8'hFF, cmd_into: 8'h80, cmd_utc: 8'h80,
                    max_restr: 16'd30, max_into: 16'hFFFF}, 48, 15, 1'b0, 1'b0, 1'b0);

        // Back to back on both sides
        run_phase(random_cfg(1'b0), 0, 0, 1'b1, 1'b0, 1'b0);

        in_if.valid <= 1'b0;
        wait_cycles = 0;
        while (tracker.due_results.size() != 0 && wait_cycles < END_WAIT_MAX) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (tracker.due_results.size() != 0) begin
            $error("%0d expected results never arrived", tracker.due_results.size());
            tracker.mismatches++;
        end
        // catch any stray result after the last expected one
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sdfp_pkg.sv
hdl/sdfp_in_if.sv
hdl/sdfp_out_if.sv
hdl/sdfp_out_buf.sv
hdl/sync_dest_frame_parser_xor_check.sv
tb/sync_dest_frame_parser_xor_check_tb.sv
